FILE: rtl/assert_macros.svh
// Assertion macros used by the checker of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked assertion, masked while the active-low reset is low.
`define HOI_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define HOI_ASSERT(name, prop, msg) \
  `HOI_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/hoi_pkg.sv
// Package for the harmonic oscillator integrator: beat types, register codes,
// reset values, saturation and divide-by-three helpers. No dependencies.
package hoi_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned OmegaW    = 31;
  localparam int unsigned StepW     = 16;
  localparam int unsigned CfgW      = 31;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned AccumW    = 51;
  localparam int unsigned DivW      = 40;
  localparam int unsigned DivDigitW = 8;
  localparam int unsigned DivSteps  = DivW / DivDigitW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic              MethodReset = 1'b1;
  localparam logic [OmegaW-1:0] OmegaReset  = 31'd65536;
  localparam logic [StepW-1:0]  StepReset   = 16'd6554;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_METHOD    = 2'd0,
    CFG_OMEGA_SQ  = 2'd1,
    CFG_STEP_SIZE = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_e;

  typedef enum logic {
    METHOD_EULER = 1'b0,
    METHOD_RK4   = 1'b1
  } method_e;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] load_position;
    logic signed [31:0] load_velocity;
  } hoi_in_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic               saturated;
  } hoi_out_t;

  // Clip to signed 32 bits. MSB of the result is the clip flag.
  function automatic logic [DataW:0] sat32(input logic signed [ProdW-1:0] v);
    logic [DataW:0] r;
    if (v[ProdW-1:DataW-1] == '0 || v[ProdW-1:DataW-1] == '1) begin
      r = {1'b0, v[DataW-1:0]};
    end else if (v[ProdW-1]) begin
      r = {1'b1, 1'b1, {(DataW-1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(DataW-1){1'b1}}};
    end
    return r;
  endfunction

  // One digit of restoring division by three: {remainder, quotient bits}.
  function automatic logic [DivDigitW+1:0] div3_digit(input logic [1:0] rem_in,
                                                     input logic [DivDigitW-1:0] bits);
    logic [1:0]           r;
    logic [2:0]           t;
    logic [DivDigitW-1:0] q;
    r = rem_in;
    q = '0;
    for (int i = DivDigitW - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= 3'd3) begin
        q[i] = 1'b1;
        r    = 2'(t - 3'd3);
      end else begin
        q[i] = 1'b0;
        r    = t[1:0];
      end
    end
    return {r, q};
  endfunction

endpackage

FILE: rtl/harmonic_oscillator_integrator_core.sv
// Harmonic oscillator integrator (x'' = -w^2 x), Euler or RK4, Q16.16.
// Depends on hoi_pkg.
//
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+---------------------------
//  in      | in  | in_valid_i / in_ready_o   | hoi_in_t  (opcode, load)
//  out     | out | out_valid_o / out_ready_i | hoi_out_t (pos, vel, sat)
//  cfg     | in  | cfg_we_i, no wait         | cfg_index_i, cfg_data_i
//
// Step beats run through the single shared 33x32 multiplier, issued once a cycle
// in RUN (3 products per derivative stage), plus a radix-256 divide by three
// for RK4; a load goes straight to FIN.
// in_ready_o is high only in IDLE; a finished result sits in the output
// register, so the next beat is taken while it waits. A result that finds
// the output register still full holds in FIN. Reset clears state, config
// to its defaults and the output valid; no clearing pass.
module harmonic_oscillator_integrator_core
  import hoi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hoi_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hoi_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [CfgW-1:0]      cfg_data_i
);

  // Rounding constants: R(n, 2^k) = (n + 2^(k-1)) >>> k.
  localparam logic signed [ProdW-1:0] RndQ16  = 64'sd32768;
  localparam logic signed [ProdW-1:0] RndQ17  = 64'sd65536;
  // R(n, 6*2^16): add 3*2^16, floor by 2^17, then floor by 3.
  localparam logic signed [ProdW-1:0] RndSix  = 64'sd196608;
  // Bias that keeps the divide-by-three operand positive.
  localparam logic signed [ProdW-1:0] DivBias = 64'sd51539607552;  // 3*2^34
  localparam logic signed [ProdW-1:0] DivUnb  = 64'sd17179869184;  // 2^34

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RUN    = 7'b0000010,
    S_TAIL   = 7'b0000100,
    S_PREP   = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_COMMIT = 7'b0100000,
    S_FIN    = 7'b1000000
  } state_e;

  // What the product in prod_q is for.
  typedef enum logic [1:0] {
    UOP_NONE = 2'd0,
    UOP_ACC  = 2'd1,   // w^2 * x      -> acceleration
    UOP_HX   = 2'd2,   // h * k_x      -> position trial + sum
    UOP_HV   = 2'd3    // h * k_v      -> velocity trial + sum
  } uop_e;

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic              method_q;
  logic [OmegaW-1:0] omega_q;
  logic [StepW-1:0]  step_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q    <= MethodReset;
      omega_q     <= OmegaReset;
      step_size_q <= StepReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_METHOD:    method_q    <= cfg_data_i[0];
        CFG_OMEGA_SQ:  omega_q     <= cfg_data_i[OmegaW-1:0];
        CFG_STEP_SIZE: step_size_q <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and state
  // ---------------------------------------------------------------------
  state_e               state_q, state_d;
  logic [1:0]           phase_q;      // 0..2 within a derivative stage
  logic [1:0]           stage_q;      // RK4 stage 0..3, Euler uses 0
  uop_e                 uop_q, uop_d;
  logic [1:0]           uop_stage_q;
  logic [DivCntW-1:0]   div_cnt_q;
  logic                 out_valid_q;
  hoi_out_t             out_q;

  logic signed [DataW-1:0]  pos_q, vel_q;     // x0, v0
  logic signed [DataW-1:0]  xt_q, vt_q;       // trial state
  logic signed [DataW-1:0]  kv_q;             // acceleration of this stage
  logic signed [AccumW-1:0] sx_q, sv_q;       // h * weighted k sums
  logic signed [ProdW-1:0]  prod_q;
  logic                     sat_q;
  logic [DivW-1:0]          dq_x_q, dq_v_q;   // dividend in, quotient out
  logic [1:0]               rem_x_q, rem_v_q;

  logic in_fire, out_free, last_stage, last_issue;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign last_stage = (method_q == METHOD_RK4) ? (stage_q == 2'd3) : (stage_q == 2'd0);
  assign last_issue = (state_q == S_RUN) && (phase_q == 2'd2) && last_stage;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (in_data_i.opcode == OP_STEP) ? S_RUN : S_FIN;
        end
      end
      S_RUN: begin
        if (last_issue) state_d = S_TAIL;
      end
      S_TAIL: begin
        state_d = (method_q == METHOD_RK4) ? S_PREP : S_COMMIT;
      end
      S_PREP:   state_d = S_DIV;
      S_DIV: begin
        if (div_cnt_q == DivCntW'(DivSteps - 1)) state_d = S_COMMIT;
      end
      S_COMMIT: state_d = S_FIN;
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Shared multiplier: issue side
  // ---------------------------------------------------------------------
  logic [DataW-1:0]         mul_a;    // omega^2 or h, unsigned
  logic signed [DataW-1:0]  mul_b;
  logic signed [DataW:0]    mul_a_s;
  logic signed [2*DataW:0]  mul_full;

  always_comb begin
    uop_d = UOP_NONE;
    mul_a = DataW'(step_size_q);
    mul_b = kv_q;
    if (state_q == S_RUN) begin
      unique case (phase_q)
        2'd0: begin
          uop_d = UOP_ACC;
          mul_a = DataW'(omega_q);
          mul_b = (stage_q == 2'd0) ? pos_q : xt_q;
        end
        2'd1: begin
          uop_d = UOP_HX;
          mul_b = (stage_q == 2'd0) ? vel_q : vt_q;
        end
        default: begin
          uop_d = UOP_HV;
          mul_b = kv_q;
        end
      endcase
    end
  end

  assign mul_a_s  = signed'({1'b0, mul_a});
  assign mul_full = mul_a_s * mul_b;

  // ---------------------------------------------------------------------
  // Consume side: round, saturate, accumulate
  // ---------------------------------------------------------------------
  logic                     half_step, dbl_weight, write_trial;
  logic signed [ProdW-1:0]  acc_round, step_round, trial_sum;
  logic [DataW:0]           acc_sat, trial_sat;
  logic signed [AccumW-1:0] prod_acc, prod_w;

  assign half_step   = (method_q == METHOD_RK4) &&
                       (uop_stage_q == 2'd0 || uop_stage_q == 2'd1);
  assign dbl_weight  = (uop_stage_q == 2'd1 || uop_stage_q == 2'd2);
  // Last RK4 stage only feeds the sums.
  assign write_trial = !((method_q == METHOD_RK4) && (uop_stage_q == 2'd3));

  assign acc_round  = (RndQ16 - prod_q) >>> 16;
  assign step_round = half_step ? ((prod_q + RndQ17) >>> 17) : ((prod_q + RndQ16) >>> 16);
  assign trial_sum  = ProdW'((uop_q == UOP_HX) ? pos_q : vel_q) + step_round;
  assign acc_sat    = sat32(acc_round);
  assign trial_sat  = sat32(trial_sum);
  assign prod_acc   = AccumW'(prod_q);
  assign prod_w     = dbl_weight ? (prod_acc <<< 1) : prod_acc;

  // ---------------------------------------------------------------------
  // RK4 final: divide by three, then add to x0 / v0
  // ---------------------------------------------------------------------
  logic signed [ProdW-1:0] div_in_x, div_in_v;
  logic [DivDigitW+1:0]    dig_x, dig_v;
  logic signed [ProdW-1:0] fin_x, fin_v;
  logic [DataW:0]          fin_x_sat, fin_v_sat;

  assign div_in_x = (((ProdW'(sx_q) + RndSix) >>> 17) + DivBias);
  assign div_in_v = (((ProdW'(sv_q) + RndSix) >>> 17) + DivBias);
  assign dig_x    = div3_digit(rem_x_q, dq_x_q[DivW-1 -: DivDigitW]);
  assign dig_v    = div3_digit(rem_v_q, dq_v_q[DivW-1 -: DivDigitW]);
  assign fin_x    = ProdW'(pos_q) + signed'(ProdW'(dq_x_q)) - DivUnb;
  assign fin_v    = ProdW'(vel_q) + signed'(ProdW'(dq_v_q)) - DivUnb;
  assign fin_x_sat = sat32(fin_x);
  assign fin_v_sat = sat32(fin_v);

  // ---------------------------------------------------------------------
  // Control and architectural state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= 2'd0;
      stage_q     <= 2'd0;
      uop_q       <= UOP_NONE;
      uop_stage_q <= 2'd0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      vel_q       <= '0;
      sat_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      uop_q       <= uop_d;
      uop_stage_q <= stage_q;

      if (in_fire) begin
        phase_q <= 2'd0;
        stage_q <= 2'd0;
        sat_q   <= 1'b0;
        if (in_data_i.opcode == OP_LOAD) begin
          pos_q <= in_data_i.load_position;
          vel_q <= in_data_i.load_velocity;
        end
      end else if (state_q == S_RUN) begin
        if (phase_q == 2'd2) begin
          phase_q <= 2'd0;
          stage_q <= stage_q + 2'd1;
        end else begin
          phase_q <= phase_q + 2'd1;
        end
      end

      // clip flags from the consume side
      if (uop_q == UOP_ACC) begin
        sat_q <= sat_q | acc_sat[DataW];
      end else if ((uop_q == UOP_HX || uop_q == UOP_HV) && write_trial) begin
        sat_q <= sat_q | trial_sat[DataW];
      end

      if (state_q == S_PREP) begin
        div_cnt_q <= '0;
      end else if (state_q == S_DIV) begin
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end

      if (state_q == S_COMMIT) begin
        if (method_q == METHOD_RK4) begin
          pos_q <= fin_x_sat[DataW-1:0];
          vel_q <= fin_v_sat[DataW-1:0];
          sat_q <= sat_q | fin_x_sat[DataW] | fin_v_sat[DataW];
        end else begin
          // Euler trial is the full step from the old state
          pos_q <= xt_q;
          vel_q <= vt_q;
        end
      end

      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers (no reset)
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[ProdW-1:0];

    if (in_fire) begin
      sx_q <= '0;
      sv_q <= '0;
    end

    unique case (uop_q)
      UOP_ACC: kv_q <= acc_sat[DataW-1:0];
      UOP_HX: begin
        sx_q <= sx_q + prod_w;
        if (write_trial) xt_q <= trial_sat[DataW-1:0];
      end
      UOP_HV: begin
        sv_q <= sv_q + prod_w;
        if (write_trial) vt_q <= trial_sat[DataW-1:0];
      end
      default: ;
    endcase

    if (state_q == S_PREP) begin
      dq_x_q  <= div_in_x[DivW-1:0];
      dq_v_q  <= div_in_v[DivW-1:0];
      rem_x_q <= 2'd0;
      rem_v_q <= 2'd0;
    end else if (state_q == S_DIV) begin
      dq_x_q  <= {dq_x_q[DivW-DivDigitW-1:0], dig_x[DivDigitW-1:0]};
      dq_v_q  <= {dq_v_q[DivW-DivDigitW-1:0], dig_v[DivDigitW-1:0]};
      rem_x_q <= dig_x[DivDigitW+1:DivDigitW];
      rem_v_q <= dig_v[DivDigitW+1:DivDigitW];
    end

    if (state_q == S_FIN && out_free) begin
      out_q.position  <= pos_q;
      out_q.velocity  <= vel_q;
      out_q.saturated <= sat_q;
    end
  end

endmodule

FILE: rtl/hoi_checker.sv
// Port-level checker for harmonic_oscillator_integrator_core, bound in below.
// Depends on hoi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hoi_checker
  import hoi_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input hoi_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input hoi_out_t out_data_o
);

  // stalled result beat holds
  `HOI_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result beat changed while stalled")

  // one beat at a time: not ready right after an accept
  `HOI_ASSERT(a_busy_after_accept, in_valid_i && in_ready_o |=> !in_ready_o, "ready right after accepting a beat")

  // a result never appears the cycle after an accept
  `HOI_ASSERT(a_no_instant_result, $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o), "result too early")

  // a load echoes its values, unclipped
  `HOI_ASSERT(a_load_echo, (in_valid_i && in_ready_o && in_data_i.opcode == OP_LOAD) ##1 (!out_valid_o || out_ready_i) |=> out_valid_o && out_data_o.position == $past(in_data_i.load_position, 2) && out_data_o.velocity == $past(in_data_i.load_velocity, 2) && !out_data_o.saturated, "load result mismatch")

endmodule

bind harmonic_oscillator_integrator_core hoi_checker u_hoi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: sim/testbench.sv
// Self-checking bench for harmonic_oscillator_integrator_core: load and step
// beats (Euler and RK4) checked against an in-bench Q16.16 predictor.
// Depends on hoi_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
  import hoi_pkg::*;

  // Slowest correct run is roughly 750 beats, each with its core work plus random
  // stalls on both sides, plus one output hold; the limit leaves a wide
  // margin.
  localparam int unsigned CycleLimit = 250000;
  localparam longint      QOne       = 64'sd65536;
  localparam int          ShowFirst  = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Input channel
  logic     in_valid = 1'b0;
  logic     in_ready;
  hoi_in_t  in_data = '0;
  // Output channel
  logic     out_valid;
  logic     out_ready = 1'b0;
  hoi_out_t out_data;
  // Register write port
  logic            cfg_we = 1'b0;
  cfg_idx_e        cfg_index = CFG_METHOD;
  logic [CfgW-1:0] cfg_data = '0;

  harmonic_oscillator_integrator_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor state: oscillator position/velocity plus a shadow of the
  // three registers. Shadow is only touched while the core is idle.
  // ---------------------------------------------------------------------
  longint  osc_pos = 0;
  longint  osc_vel = 0;
  method_e cfg_method = METHOD_RK4;
  longint  cfg_omega_sq = 64'sd65536;
  longint  cfg_step = 64'sd6554;
  bit      step_clipped;

  hoi_in_t  pending_beats[$];    // beats waiting to be offered
  hoi_out_t expected_states[$];  // predicted results, oldest first

  int cycle_count = 0;
  int fail_count = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic calm;

  // Stretch of the run with no random idling on either side.
  assign calm = (cycle_count >= 6000) && (cycle_count < 12000);

  // floor(n / d) for d > 0
  function automatic longint floor_quot(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // Round to nearest, ties toward +inf
  function automatic longint round_div(longint n, longint d);
    return floor_quot(n + d / 2, d);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      step_clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      step_clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // a = -w^2 * x
  function automatic longint spring_accel(longint x);
    return clip32(round_div(-(cfg_omega_sq * x), QOne));
  endfunction

  // Applies one beat to the oscillator state and returns what the core
  // should report for it.
  function automatic hoi_out_t advance_oscillator(hoi_in_t beat);
    longint   x0, v0, a1, a2, a3, a4;
    longint   x2, v2, x3, v3, x4, v4;
    hoi_out_t res;
    step_clipped = 1'b0;
    if (beat.opcode == OP_LOAD) begin
      osc_pos = $signed(beat.load_position);
      osc_vel = $signed(beat.load_velocity);
    end else begin
      x0 = osc_pos;
      v0 = osc_vel;
      a1 = spring_accel(x0);
      if (cfg_method == METHOD_EULER) begin
        osc_pos = clip32(x0 + round_div(cfg_step * v0, QOne));
        osc_vel = clip32(v0 + round_div(cfg_step * a1, QOne));
      end else begin
        // two half-step probes, then one full-step probe
        x2 = clip32(x0 + round_div(cfg_step * v0, 2 * QOne));
        v2 = clip32(v0 + round_div(cfg_step * a1, 2 * QOne));
        a2 = spring_accel(x2);
        x3 = clip32(x0 + round_div(cfg_step * v2, 2 * QOne));
        v3 = clip32(v0 + round_div(cfg_step * a2, 2 * QOne));
        a3 = spring_accel(x3);
        x4 = clip32(x0 + round_div(cfg_step * v3, QOne));
        v4 = clip32(v0 + round_div(cfg_step * a3, QOne));
        a4 = spring_accel(x4);
        osc_pos = clip32(x0 + round_div(cfg_step * (v0 + 2 * v2 + 2 * v3 + v4), 6 * QOne));
        osc_vel = clip32(v0 + round_div(cfg_step * (a1 + 2 * a2 + 2 * a3 + a4), 6 * QOne));
      end
    end
    res.position  = osc_pos[31:0];
    res.velocity  = osc_vel[31:0];
    res.saturated = step_clipped;
    return res;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers queued beats, holds valid/payload until accepted, and
  // predicts each beat at the edge where it is taken.
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_states.push_back(advance_oscillator(in_data));
      end
      if (!in_valid || in_ready) begin
        if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
          in_data  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each result beat against the oldest prediction and
  // drives out_ready, including one long hold-off so the core backs up.
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    hoi_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_states.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= ShowFirst) begin
            $display("[%0t] unexpected result beat: pos=%0d vel=%0d sat=%0b",
                     $realtime, out_data.position, out_data.velocity, out_data.saturated);
          end
        end else begin
          want = expected_states.pop_front();
          if (out_data.position !== want.position || out_data.velocity !== want.velocity ||
              out_data.saturated !== want.saturated) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= ShowFirst) begin
              $display("[%0t] result %0d: exp pos=%0d vel=%0d sat=%0b, got pos=%0d vel=%0d sat=%0b",
                       $realtime, results_seen, want.position, want.velocity, want.saturated,
                       out_data.position, out_data.velocity, out_data.saturated);
            end
          end
        end
      end
      // long back-pressure once, early in the random traffic
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen == 60) begin
        hold_done = 1'b1;
        hold_left = 400;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 19);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic queue_load(logic [31:0] pos, logic [31:0] vel);
    hoi_in_t b;
    b.opcode        = OP_LOAD;
    b.load_position = pos;
    b.load_velocity = vel;
    pending_beats.push_back(b);
  endtask

  // load fields carry junk; the core must ignore them on a step
  task automatic queue_step();
    hoi_in_t b;
    b.opcode        = OP_STEP;
    b.load_position = $urandom;
    b.load_velocity = $urandom;
    pending_beats.push_back(b);
  endtask

  // Sender pause: nothing offered, nothing outstanding. Sampled on the
  // falling edge so the driver's rising-edge updates have settled.
  task automatic wait_until_settled();
    @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_states.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Register write; only called with the core idle.
  task automatic set_register(cfg_idx_e idx, logic [CfgW-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_METHOD:    cfg_method = method_e'(value[0]);
      CFG_OMEGA_SQ:  cfg_omega_sq = longint'(value);
      CFG_STEP_SIZE: cfg_step = longint'(value[StepW-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_all(method_e m, logic [CfgW-1:0] w2, logic [CfgW-1:0] h);
    set_register(CFG_METHOD, CfgW'(m));
    set_register(CFG_OMEGA_SQ, w2);
    set_register(CFG_STEP_SIZE, h);
  endtask

  // Mix of full-range, physically sensible and corner Q16.16 values.
  function automatic logic [31:0] pick_q16();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(1 << 20)) - (1 << 19));
      2: return 32'(int'($urandom_range(1 << 28)) - (1 << 27));
      default: begin
        case ($urandom_range(4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0000_0001;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic logic [CfgW-1:0] pick_omega_sq();
    case ($urandom_range(2))
      0: return CfgW'($urandom_range(4 * 65536));
      1: return CfgW'($urandom);
      default: return $urandom_range(1) ? CfgW'(0) : {CfgW{1'b1}};
    endcase
  endfunction

  // Mostly load-then-step runs, which is where the integrator does its
  // work; the rest is lone steps, lone loads and the odd sender pause.
  task automatic random_run(int n_beats);
    int sent;
    int burst;
    int roll;
    sent = 0;
    while (sent < n_beats) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        queue_load(pick_q16(), pick_q16());
        burst = $urandom_range(1, 10);
        repeat (burst) queue_step();
        sent += burst + 1;
      end else if (roll < 84) begin
        queue_step();
        sent++;
      end else if (roll < 96) begin
        queue_load(pick_q16(), pick_q16());
        sent++;
      end else begin
        wait_until_settled();
      end
    end
    wait_until_settled();
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset config (RK4, w^2 = 1.0, h ~ 0.1)
    queue_step();                                    // step from the cleared state
    queue_load(32'h0001_0000, 32'h0000_0000);        // x = 1.0 at rest
    repeat (3) queue_step();
    queue_load(32'h0000_0000, 32'hFFFF_0000);        // v = -1.0
    queue_step();
    queue_load(32'h7FFF_FFFF, 32'h8000_0000);        // extremes, clip on step
    repeat (2) queue_step();
    queue_load(32'h8000_0000, 32'h7FFF_FFFF);
    queue_step();
    queue_load(32'hFFFF_FFFF, 32'h0000_0001);        // one LSB either side
    queue_step();
    queue_load(32'h5555_5555, 32'hAAAA_AAAA);
    queue_step();
    wait_until_settled();

    // Directed Euler, including clipping on a forward Euler step
    set_all(METHOD_EULER, CfgW'(65536), CfgW'(6554));
    queue_load(32'h0001_0000, 32'h0000_8000);
    repeat (2) queue_step();
    queue_load(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_step();
    wait_until_settled();

    // Directed zero step size: state must not move
    set_register(CFG_STEP_SIZE, CfgW'(0));
    queue_load(32'h0001_E240, 32'hFFF6_0C0F);
    repeat (2) queue_step();
    wait_until_settled();

    // Random phases across register settings, extremes included
    set_all(METHOD_EULER, CfgW'(4 * 65536), CfgW'(3277));
    random_run(120);

    set_all(METHOD_RK4, {CfgW{1'b1}}, CfgW'(16'hFFFF));
    random_run(80);

    set_all(METHOD_EULER, CfgW'(0), CfgW'(0));
    random_run(60);

    set_all(METHOD_RK4, CfgW'(0), CfgW'(16'hFFFF));
    random_run(60);

    set_all(METHOD_RK4, pick_omega_sq(), CfgW'($urandom_range(16'hFFFF)));
    random_run(120);

    set_all(METHOD_EULER, pick_omega_sq(), CfgW'($urandom_range(16'hFFFF)));
    random_run(120);

    set_all(METHOD_RK4, pick_omega_sq(), CfgW'(0));
    random_run(50);

    set_all(METHOD_RK4, CfgW'(65536), CfgW'(6554));
    random_run(100);

    // Tail: let any stray beat show up
    repeat (60) @(posedge clk);
    if (expected_states.size() != 0) fail_count++;

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/hoi_pkg.sv
rtl/harmonic_oscillator_integrator_core.sv
rtl/hoi_checker.sv
sim/testbench.sv
